>>> hdl/and_gate_structural_hash_core_defines.svh
// Assertion macros for the structural hash core
`ifndef AND_GATE_STRUCTURAL_HASH_CORE_DEFINES_SVH
`define AND_GATE_STRUCTURAL_HASH_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define SH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define SH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

>>> hdl/agsh_pkg.sv
//------------------------------------------------------------------------------
// agsh_pkg
// Shared types and constants of the AND gate structural hash core.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package agsh_pkg;

    localparam int BKT_CNT      = 256;
    localparam int BUCKET_DEPTH = 8;
    localparam int MAX_GATES    = 4096;
    localparam int VAR_BITS     = 20;

    localparam int BK_W    = $clog2(BKT_CNT);
    localparam int SLOT_W  = $clog2(BUCKET_DEPTH);
    localparam int FILL_W  = $clog2(BUCKET_DEPTH + 1);
    localparam int GIDX_W  = $clog2(MAX_GATES);
    localparam int GCNT_W  = $clog2(MAX_GATES + 1);
    localparam int LIT_W   = 21;
    localparam int GATE_W  = VAR_BITS + 2 * LIT_W;
    localparam int BSLOT_D = BKT_CNT * BUCKET_DEPTH;
    localparam int BSLOT_W = $clog2(BSLOT_D);

    localparam logic [31:0] HASH_MUL = 32'd17;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TBL_FULL  = 2'd1;
    localparam logic [1:0] ST_BKT_FULL  = 2'd2;
    localparam logic [1:0] ST_VAR_RANGE = 2'd3;

    localparam logic REG_HASH_EN   = 1'b0;
    localparam logic REG_FIRST_AUX = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic hash;      // compute bucket, read fill
        logic gate_rd;   // issue gate table read
        logic cmp;       // compare gate read data
        logic decide;    // compute outcome
        logic commit;    // write state, emit
    } agsh_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic probe_more;  // more slots to probe
    } agsh_stat_t;

endpackage

>>> hdl/and_gate_structural_hash_core.sv
//------------------------------------------------------------------------------
// and_gate_structural_hash_core
// Adds AND gates with structural hashing; shares identical gates when hashing is on and no variable is given.
//------------------------------------------------------------------------------
// channel  | handshake          | payload
// config   | cfg_we             | cfg_idx, cfg_data
// input    | start & !busy      | given_var, fan_in_a, fan_in_b
// result   | done (one cycle)   | out_var, was_shared, status, highest_var,
//          |                    | gate_count
// Each bucket slot, up to 8 per item, is read from the slot RAM, then the gate
// RAM, then compared. The result strobe is registered after the last step and
// comes in the cycle after it; start is taken again in that cycle. Reset clears
// one valid bit per bucket at once; no clearing pass. The receiver cannot stall.
`timescale 1ns / 1ps

module and_gate_structural_hash_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_idx,
    input  logic [19:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [19:0]        given_var,
    input  logic signed [20:0] fan_in_a,
    input  logic signed [20:0] fan_in_b,
    output logic               done,
    output logic [19:0]        out_var,
    output logic               was_shared,
    output logic [1:0]         status,
    output logic [19:0]        highest_var,
    output logic [12:0]        gate_count
);

    agsh_pkg::agsh_cmd_t  cmd;
    agsh_pkg::agsh_stat_t stat;

    agsh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    agsh_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .given_var   (given_var),
        .fan_in_a    (fan_in_a),
        .fan_in_b    (fan_in_b),
        .done        (done),
        .out_var     (out_var),
        .was_shared  (was_shared),
        .status      (status),
        .highest_var (highest_var),
        .gate_count  (gate_count)
    );

endmodule

>>> hdl/agsh_ram.sv
//------------------------------------------------------------------------------
// agsh_ram
// Generic single-port-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module agsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/agsh_ctrl.sv
//------------------------------------------------------------------------------
// agsh_ctrl
// Sequencer: hash, probe bucket slots one by one, decide, commit.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "and_gate_structural_hash_core_defines.svh"

module agsh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output agsh_pkg::agsh_cmd_t cmd,
    input  agsh_pkg::agsh_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE, S_HASH, S_SLOT, S_GATE, S_WAIT, S_CMP, S_DECIDE, S_COMMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (start) state_next = S_HASH;
            S_HASH:   state_next = S_SLOT;
            S_SLOT:   state_next = stat.probe_more ? S_GATE : S_DECIDE;
            S_GATE:   state_next = S_WAIT;
            S_WAIT:   state_next = S_CMP;
            S_CMP:    state_next = (stat.hit || !stat.probe_more) ? S_DECIDE : S_GATE;
            S_DECIDE: state_next = S_COMMIT;
            S_COMMIT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd         = '0;
        cmd.load    = (state_reg == S_IDLE) && start;
        cmd.hash    = (state_reg == S_HASH);
        cmd.gate_rd = (state_reg == S_GATE);
        cmd.cmp     = (state_reg == S_CMP);
        cmd.decide  = (state_reg == S_DECIDE);
        cmd.commit  = (state_reg == S_COMMIT);
    end

    `SH_ASSERT_NEXT(a_load_hash, cmd.load, state_reg == S_HASH)
    `SH_ASSERT_NEXT(a_decide_commit, state_reg == S_DECIDE, cmd.commit)
    `SH_ASSERT_NEXT(a_commit_idle, cmd.commit, !busy)

endmodule

>>> hdl/agsh_dp.sv
//------------------------------------------------------------------------------
// agsh_dp
// Datapath: literal ordering, bucket hash, fill store, slot and gate RAMs.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "and_gate_structural_hash_core_defines.svh"

module agsh_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  agsh_pkg::agsh_cmd_t  cmd,
    output agsh_pkg::agsh_stat_t stat,
    input  logic                 cfg_we,
    input  logic                 cfg_idx,
    input  logic [19:0]          cfg_data,
    input  logic [19:0]          given_var,
    input  logic signed [20:0]   fan_in_a,
    input  logic signed [20:0]   fan_in_b,
    output logic                 done,
    output logic [19:0]          out_var,
    output logic                 was_shared,
    output logic [1:0]           status,
    output logic [19:0]          highest_var,
    output logic [12:0]          gate_count
);

    localparam int BK_W   = agsh_pkg::BK_W;
    localparam int SLOT_W = agsh_pkg::SLOT_W;
    localparam int FILL_W = agsh_pkg::FILL_W;
    localparam int GIDX_W = agsh_pkg::GIDX_W;
    localparam int GCNT_W = agsh_pkg::GCNT_W;
    localparam int VB     = agsh_pkg::VAR_BITS;
    localparam int LW     = agsh_pkg::LIT_W;

    // config and architectural state
    logic              hash_en_reg;
    logic [VB-1:0]     aux_reg;
    logic [VB-1:0]     maxv_reg;
    logic [GCNT_W-1:0] cnt_reg;
    logic [31:0]       shared_reg;
    logic [agsh_pkg::BKT_CNT-1:0] bkt_vld_reg;

    // per-item registers
    logic [19:0]        given_reg;
    logic signed [LW-1:0] a_reg, b_reg;
    logic [BK_W-1:0]    bk_reg;
    logic               fvld_reg;
    logic [FILL_W-1:0]  probe_reg;
    logic               hit_reg;
    logic [VB-1:0]      hit_var_reg;
    logic [VB-1:0]      lhs_reg;
    logic [1:0]         st_reg;
    logic               shr_reg;
    logic               app_reg;
    logic               bkw_reg;

    // output registers
    logic               done_reg;
    logic [19:0]        ov_reg;
    logic               ws_reg;
    logic [1:0]         so_reg;

    logic signed [LW-1:0] a_ord, b_ord;
    logic [31:0] hash_w;
    logic [FILL_W-1:0] fill_rdata, fill_cur;
    logic [GIDX_W-1:0] slot_rdata;
    logic [agsh_pkg::GATE_W-1:0] gate_rdata, gate_wdata;
    logic slot_we, gate_we;

    assign a_ord  = (fan_in_a > fan_in_b) ? fan_in_b : fan_in_a;
    assign b_ord  = (fan_in_a > fan_in_b) ? fan_in_a : fan_in_b;
    assign hash_w = (32'(a_reg) * agsh_pkg::HASH_MUL) ^ 32'(b_reg);

    // a bucket never written since reset reads as empty
    assign fill_cur = fvld_reg ? fill_rdata : '0;

    assign slot_we    = cmd.commit && app_reg && bkw_reg;
    assign gate_we    = cmd.commit && app_reg;
    assign gate_wdata = {lhs_reg, a_reg, b_reg};

    // fill RAM address follows the held literals, so data is ready in the cycle after hash
    agsh_ram #(.WIDTH(FILL_W), .DEPTH(agsh_pkg::BKT_CNT)) u_fill (
        .clk   (clk),
        .we    (slot_we),
        .waddr (bk_reg),
        .wdata (fill_cur + FILL_W'(1)),
        .raddr (hash_w[BK_W-1:0]),
        .rdata (fill_rdata)
    );

    agsh_ram #(.WIDTH(GIDX_W), .DEPTH(agsh_pkg::BSLOT_D)) u_slots (
        .clk   (clk),
        .we    (slot_we),
        .waddr ({bk_reg, fill_cur[SLOT_W-1:0]}),
        .wdata (cnt_reg[GIDX_W-1:0]),
        .raddr ({bk_reg, probe_reg[SLOT_W-1:0]}),
        .rdata (slot_rdata)
    );

    agsh_ram #(.WIDTH(agsh_pkg::GATE_W), .DEPTH(agsh_pkg::MAX_GATES)) u_gates (
        .clk   (clk),
        .we    (gate_we),
        .waddr (cnt_reg[GIDX_W-1:0]),
        .wdata (gate_wdata),
        .raddr (slot_rdata),
        .rdata (gate_rdata)
    );

    logic match;
    assign match = (gate_rdata[2*LW-1:LW] == a_reg) && (gate_rdata[LW-1:0] == b_reg);

    assign stat.hit        = hit_reg || (cmd.cmp && match);
    // during compare, ask whether a slot beyond the current one exists
    assign stat.probe_more = hash_en_reg
                             && ((cmd.cmp ? probe_reg + FILL_W'(1) : probe_reg) < fill_cur);

    // bucket valid bits: cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bkt_vld_reg <= '0;
        end
        else if (slot_we)
        begin
            bkt_vld_reg[bk_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_en_reg <= 1'b1;
            aux_reg     <= VB'(1);
            maxv_reg    <= '0;
            cnt_reg     <= '0;
            shared_reg  <= '0;
            done_reg    <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    agsh_pkg::REG_HASH_EN:   hash_en_reg <= cfg_data[0];
                    agsh_pkg::REG_FIRST_AUX: aux_reg     <= cfg_data[VB-1:0];
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                hit_reg <= 1'b0;
            end
            if (cmd.cmp && match && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                if (shr_reg)
                begin
                    shared_reg <= shared_reg + 32'd1;
                end
                if (app_reg)
                begin
                    cnt_reg <= cnt_reg + GCNT_W'(1);
                    if (lhs_reg > maxv_reg)
                    begin
                        maxv_reg <= lhs_reg;
                    end
                    if (given_reg == '0)
                    begin
                        aux_reg <= aux_reg + VB'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            given_reg <= given_var;
            a_reg     <= a_ord;
            b_reg     <= b_ord;
        end
        if (cmd.hash)
        begin
            bk_reg    <= hash_w[BK_W-1:0];
            fvld_reg  <= bkt_vld_reg[hash_w[BK_W-1:0]];
            probe_reg <= '0;
        end
        if (cmd.cmp)
        begin
            if (match && !hit_reg)
            begin
                hit_var_reg <= gate_rdata[agsh_pkg::GATE_W-1:2*LW];
            end
            else if (!match)
            begin
                probe_reg <= probe_reg + FILL_W'(1);
            end
        end
        if (cmd.decide)
        begin
            shr_reg <= 1'b0;
            app_reg <= 1'b0;
            bkw_reg <= hash_en_reg && !hit_reg;
            st_reg  <= agsh_pkg::ST_OK;
            lhs_reg <= (given_reg == '0) ? aux_reg : given_reg[VB-1:0];
            if (hash_en_reg && hit_reg && given_reg == '0)
            begin
                shr_reg <= 1'b1;
                lhs_reg <= hit_var_reg;
            end
            else if (cnt_reg >= GCNT_W'(agsh_pkg::MAX_GATES))
            begin
                st_reg <= agsh_pkg::ST_TBL_FULL;
            end
            else if (hash_en_reg && !hit_reg
                     && fill_cur >= FILL_W'(agsh_pkg::BUCKET_DEPTH))
            begin
                st_reg <= agsh_pkg::ST_BKT_FULL;
            end
            else if ((given_reg == '0) ? (aux_reg == '0)
                     : (32'(given_reg) > ((32'd1 << VB) - 32'd1)))
            begin
                st_reg <= agsh_pkg::ST_VAR_RANGE;
            end
            else
            begin
                app_reg <= 1'b1;
            end
        end
        if (cmd.commit)
        begin
            ov_reg <= (shr_reg || app_reg) ? 20'(lhs_reg) : 20'd0;
            ws_reg <= shr_reg;
            so_reg <= st_reg;
        end
    end

    assign done        = done_reg;
    assign out_var     = ov_reg;
    assign was_shared  = ws_reg;
    assign status      = so_reg;
    assign highest_var = 20'(maxv_reg);
    assign gate_count  = 13'(cnt_reg);

    `SH_ASSERT_IMP(a_probe_bound, cmd.cmp, probe_reg < fill_cur)
    `SH_ASSERT_NEXT(a_cnt_grow, cmd.commit && app_reg, cnt_reg == $past(cnt_reg) + 1'b1)
    `SH_ASSERT_IMP(a_shared_ok, done && was_shared, status == agsh_pkg::ST_OK)

endmodule
